FILE: hw/rtl/qpwu_pkg.sv
// ----------------------------------------------------------------------------
// qpwu_pkg
// Shared types, constants and helpers of the quickprop weight update core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qpwu_pkg;

  localparam int CONNECTIONS = 1024;
  localparam int CONN_AW     = $clog2(CONNECTIONS);
  localparam int FRAC_BITS   = 16;
  localparam int META_W      = 96;

  localparam logic signed [63:0] MAX32 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MIN32 = -64'sh0000_0000_8000_0000;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_ACCUM  = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_STEP_RATE  = 3'd0,
    REG_DECAY_RATE = 3'd1,
    REG_MAX_GROWTH = 3'd2,
    REG_SHRINK     = 3'd3,
    REG_LIMIT      = 3'd4,
    REG_LIMIT_EN   = 3'd5,
    REG_RESTART    = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_idx_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > MAX32) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < MIN32) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/qpwu_ram.sv
// ----------------------------------------------------------------------------
// qpwu_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpwu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/qpwu_div.sv
// ----------------------------------------------------------------------------
// qpwu_div
// Signed 64 by 33 bit divider, one quotient bit per cycle, quotient truncated
// toward zero and saturated to 32 bits. Divisor must be nonzero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpwu_div
  import qpwu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [63:0] num,
  input  logic signed [32:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  typedef enum logic [2:0] {
    D_IDLE  = 3'b001,
    D_CHECK = 3'b010,
    D_RUN   = 3'b100
  } div_state_t;

  div_state_t state;
  logic        sign;
  logic [62:0] mag_n;
  logic [32:0] mag_d;
  logic [32:0] rem;
  logic [30:0] low;
  logic [30:0] q;
  logic [4:0]  cnt;

  logic [63:0] num_abs;
  logic [32:0] den_abs;
  logic [33:0] trial;
  logic        qbit;
  logic [32:0] rem_next;
  logic [30:0] q_next;

  always_comb begin
    num_abs  = num[63] ? 64'(-num) : 64'(num);
    den_abs  = den[32] ? 33'(-den) : 33'(den);
    trial    = {rem, low[30]};
    qbit     = trial >= {1'b0, mag_d};
    rem_next = qbit ? 33'(trial - {1'b0, mag_d}) : trial[32:0];
    q_next   = {q[29:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (go) begin
            sign  <= num[63] ^ den[32];
            mag_n <= num_abs[62:0];
            mag_d <= den_abs;
            state <= D_CHECK;
          end
        end
        D_CHECK: begin
          if ({1'b0, mag_n[62:31]} >= mag_d) begin
            quot  <= sign ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            rem   <= {1'b0, mag_n[62:31]};
            low   <= mag_n[30:0];
            q     <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= rem_next;
          low <= {low[29:0], 1'b0};
          q   <= q_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd30) begin
            quot  <= sign ? 32'(-$signed({1'b0, q_next})) : $signed({1'b0, q_next});
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/quickprop_weight_update_core.sv
// ----------------------------------------------------------------------------
// quickprop_weight_update_core
// Per-connection quickprop weight update over a weight memory and a memory of
// step, previous slope and slope sum records.
// ----------------------------------------------------------------------------
// channel   direction  signals                               beat taken when
// item      in         start busy op connection value        start & !busy
// result    out        done weight step overflowed           done (one cycle)
//                      overflow_count
// config    in         cfg_valid cfg_ready cfg_index cfg_data cfg_valid & cfg_ready
//
// write, accumulate and unused ops go through the read and final states.
// an update runs the decay, slope, eps, shrink, grow, num and decide states,
// plus the divide state when the quadratic term needs the bit-serial divider;
// the shared 33x33 multiplier and the divider shape it. one item is in flight
// at a time. a clearing pass over all 1024 records after reset zeroes the
// record memory while busy is high. config writes are taken in every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quickprop_weight_update_core
  import qpwu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op,
  input  logic [CONN_AW-1:0]  connection,
  input  logic signed [31:0]  value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                done,
  output logic signed [31:0]  weight,
  output logic signed [31:0]  step,
  output logic                overflowed,
  output logic [15:0]         overflow_count
);

  typedef enum logic [11:0] {
    ST_CLEAR  = 12'b0000_0000_0001,
    ST_IDLE   = 12'b0000_0000_0010,
    ST_READ   = 12'b0000_0000_0100,
    ST_DECAY  = 12'b0000_0000_1000,
    ST_SLOPE  = 12'b0000_0001_0000,
    ST_EPS    = 12'b0000_0010_0000,
    ST_SHRINK = 12'b0000_0100_0000,
    ST_GROW   = 12'b0000_1000_0000,
    ST_NUM    = 12'b0001_0000_0000,
    ST_DECIDE = 12'b0010_0000_0000,
    ST_DIV    = 12'b0100_0000_0000,
    ST_FINAL  = 12'b1000_0000_0000
  } state_t;

  state_t state;
  logic [CONN_AW-1:0] clr_cnt;

  logic [30:0] step_rate, decay_rate, max_growth, weight_limit;
  logic [16:0] shrink_factor;
  logic        limit_enable;
  logic signed [31:0] restart_weight;

  op_t                op_r;
  logic [CONN_AW-1:0] conn_r;
  logic signed [31:0] value_r;

  logic signed [31:0] w_rd;
  logic [META_W-1:0]  meta_rd;
  logic signed [31:0] d, p, sum;

  logic signed [63:0] prod;
  logic signed [31:0] s;
  logic signed [63:0] eps, sp, mud, base, term;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic               w_we, m_we, rd_en;
  logic [CONN_AW-1:0] m_addr;
  logic signed [31:0] w_wdata;
  logic [META_W-1:0]  m_wdata;

  logic               div_go, div_done;
  logic signed [31:0] div_quot;
  logic signed [32:0] den;

  logic signed [63:0] s_full;
  logic               d_zero, s_pos, use_mu, take_quad;
  logic signed [63:0] base_next;

  logic signed [31:0] dw, nw, sum_acc;
  logic               over;
  logic signed [31:0] res_w, res_st;

  assign {d, p, sum} = meta_rd;
  assign busy        = state != ST_IDLE;
  assign cfg_ready   = 1'b1;

  qpwu_ram #(.WIDTH(32), .DEPTH(CONNECTIONS)) u_wram (
    .clk   (clk),
    .we    (w_we),
    .waddr (conn_r),
    .wdata (w_wdata),
    .re    (rd_en),
    .raddr (conn_r),
    .rdata (w_rd)
  );

  qpwu_ram #(.WIDTH(META_W), .DEPTH(CONNECTIONS)) u_mram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_addr),
    .wdata (m_wdata),
    .re    (rd_en),
    .raddr (conn_r),
    .rdata (meta_rd)
  );

  qpwu_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (prod),
    .den  (den),
    .done (div_done),
    .quot (div_quot)
  );

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_DECAY:  begin mul_a = {2'b00, decay_rate};  mul_b = 33'(w_rd); end
      ST_EPS:    begin mul_a = {2'b00, step_rate};   mul_b = 33'(s);    end
      ST_SHRINK: begin mul_a = {16'b0, shrink_factor}; mul_b = 33'(p);  end
      ST_GROW:   begin mul_a = {2'b00, max_growth};  mul_b = 33'(d);    end
      ST_NUM:    begin mul_a = 33'(d);               mul_b = 33'(s);    end
      default:   begin mul_a = '0;                   mul_b = '0;        end
    endcase
    mul_p = mul_a * mul_b;
  end

  // branch decision
  always_comb begin
    s_full    = 64'(s) <<< FRAC_BITS;
    d_zero    = d == 32'sd0;
    s_pos     = !s[31] && (s != 32'sd0);
    den       = 33'(p) - 33'(s);
    if (d_zero) begin
      base_next = -eps;
    end else if (d[31]) begin
      base_next = s_pos ? -eps : 64'sd0;
    end else begin
      base_next = s[31] ? -eps : 64'sd0;
    end
    use_mu    = d[31] ? (s_full >= sp) : (s_full <= sp);
    take_quad = !d_zero && !use_mu;
    div_go    = (state == ST_DECIDE) && take_quad && (den != 33'sd0);
  end

  // final results, write-back and record clearing
  always_comb begin
    dw      = sat32(base + term);
    nw      = sat32(64'(w_rd) + 64'(dw));
    over    = limit_enable && ($signed({nw[31], nw}) > $signed({2'b00, weight_limit}));
    sum_acc = sat32(64'(sum) + 64'(value_r));
    w_we    = 1'b0;
    m_we    = 1'b0;
    m_addr  = conn_r;
    w_wdata = value_r;
    m_wdata = '0;
    res_w   = w_rd;
    res_st  = d;
    if (state == ST_CLEAR) begin
      m_we   = 1'b1;
      m_addr = clr_cnt;
    end else if (state == ST_FINAL) begin
      case (op_r)
        OP_WRITE: begin
          w_we   = 1'b1;
          m_we   = 1'b1;
          res_w  = value_r;
          res_st = 32'sd0;
        end
        OP_ACCUM: begin
          m_we    = 1'b1;
          m_wdata = {d, p, sum_acc};
        end
        OP_UPDATE: begin
          w_we = 1'b1;
          m_we = 1'b1;
          if (over) begin
            w_wdata = restart_weight;
            res_w   = restart_weight;
            res_st  = 32'sd0;
          end else begin
            w_wdata = nw;
            m_wdata = {dw, s, 32'sd0};
            res_w   = nw;
            res_st  = dw;
          end
        end
        default: begin
          w_we = 1'b0;
        end
      endcase
    end
  end

  assign rd_en = state == ST_READ;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate      <= 31'd655360;
      decay_rate     <= 31'd0;
      max_growth     <= 31'd131072;
      shrink_factor  <= 17'd43690;
      weight_limit   <= 31'd655360000;
      limit_enable   <= 1'b1;
      restart_weight <= 32'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEP_RATE:  step_rate      <= cfg_data[30:0];
        REG_DECAY_RATE: decay_rate     <= cfg_data[30:0];
        REG_MAX_GROWTH: max_growth     <= cfg_data[30:0];
        REG_SHRINK:     shrink_factor  <= cfg_data[16:0];
        REG_LIMIT:      weight_limit   <= cfg_data[30:0];
        REG_LIMIT_EN:   limit_enable   <= cfg_data[0];
        REG_RESTART:    restart_weight <= $signed(cfg_data);
        default:        limit_enable   <= limit_enable;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_cnt        <= '0;
      done           <= 1'b0;
      overflow_count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CONN_AW'(CONNECTIONS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            op_r    <= op_t'(op);
            conn_r  <= connection;
            value_r <= value;
            state   <= ST_READ;
          end
        end
        ST_READ: begin
          state <= (op_r == OP_UPDATE) ? ST_DECAY : ST_FINAL;
        end
        ST_DECAY: begin
          prod  <= mul_p[63:0];
          state <= ST_SLOPE;
        end
        ST_SLOPE: begin
          s     <= sat32(64'(sum) + (prod >>> FRAC_BITS));
          state <= ST_EPS;
        end
        ST_EPS: begin
          prod  <= mul_p[63:0];
          state <= ST_SHRINK;
        end
        ST_SHRINK: begin
          eps   <= prod >>> FRAC_BITS;
          prod  <= mul_p[63:0];
          state <= ST_GROW;
        end
        ST_GROW: begin
          sp    <= prod;
          prod  <= mul_p[63:0];
          state <= ST_NUM;
        end
        ST_NUM: begin
          mud   <= prod >>> FRAC_BITS;
          prod  <= mul_p[63:0];
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          base <= base_next;
          if (!take_quad) begin
            term  <= d_zero ? 64'sd0 : mud;
            state <= ST_FINAL;
          end else if (den == 33'sd0) begin
            if (prod > 64'sd0) begin
              term <= MAX32;
            end else if (prod < 64'sd0) begin
              term <= MIN32;
            end else begin
              term <= 64'sd0;
            end
            state <= ST_FINAL;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            term  <= 64'(div_quot);
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          done       <= 1'b1;
          weight     <= res_w;
          step       <= res_st;
          overflowed <= (op_r == OP_UPDATE) && over;
          if ((op_r == OP_UPDATE) && over && (overflow_count != 16'hFFFF)) begin
            overflow_count <= overflow_count + 16'd1;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/qpwu_checker.sv
// ----------------------------------------------------------------------------
// qpwu_checker
// Port-level checks of the quickprop weight update core, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpwu_checker
  import qpwu_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic                overflowed,
  input logic [15:0]         overflow_count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result beats in a row");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    done && !overflowed && !$past(rst) |-> overflow_count == $past(overflow_count))
    else $error("overflow count moved without an overflow");

endmodule

bind quickprop_weight_update_core qpwu_checker u_qpwu_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .overflowed     (overflowed),
  .overflow_count (overflow_count)
);

FILE: sim/quickprop_weight_update_core_tb.sv
// ----------------------------------------------------------------------------
// quickprop_weight_update_core_tb
// Self-checking bench for the quickprop weight update core. A predictor keeps
// its own copy of the weight and record memories and of the register file.
// Directed beats hit the field extremes, every op, slope and weight saturation,
// limit restoration and the zero-divisor quadratic step. Random phases then run
// write/accumulate/update sequences under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quickprop_weight_update_core_tb;
  import qpwu_pkg::*;

  localparam longint HI32 = 64'sd2147483647;
  localparam longint LO32 = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 60;

  typedef struct {
    int weight;
    int step;
    bit overflowed;
    bit [15:0] count;
  } outcome_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] op;
  logic [CONN_AW-1:0] connection;
  logic signed [31:0] value;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic done;
  logic signed [31:0] weight;
  logic signed [31:0] step;
  logic overflowed;
  logic [15:0] overflow_count;

  quickprop_weight_update_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .connection(connection), .value(value), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .weight(weight), .step(step), .overflowed(overflowed),
    .overflow_count(overflow_count)
  );

  // predictor state
  int weights [CONNECTIONS];
  int steps [CONNECTIONS];
  int slopes [CONNECTIONS];
  int slope_sums [CONNECTIONS];
  bit written [CONNECTIONS];
  int unsigned restore_tally;
  longint eps_q, decay_q, growth_q, shrink_q, limit_q, restart_q;
  bit limit_on;

  outcome_t pending_results[$];
  int errors;
  int items_sent;
  int results_seen;
  int restores_seen;
  int quad_hits;
  int cycles;
  int pool [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint clamp32(longint x);
    if (x > HI32) return HI32;
    if (x < LO32) return LO32;
    return x;
  endfunction

  function automatic longint quad_step(longint d, longint s, longint p);
    longint num, den;
    num = d * s;
    den = p - s;
    quad_hits++;
    if (den == 0) begin
      if (num > 0) return HI32;
      if (num < 0) return LO32;
      return 0;
    end
    return clamp32(num / den);
  endfunction

  function automatic outcome_t apply_item(op_t o, int c, int v);
    outcome_t r;
    longint w, d, p, s, eps_s, sp, dw, nw;
    r.overflowed = 1'b0;
    case (o)
      OP_WRITE: begin
        weights[c] = v;
        steps[c] = 0;
        slopes[c] = 0;
        slope_sums[c] = 0;
        written[c] = 1'b1;
      end
      OP_ACCUM: begin
        slope_sums[c] = int'(clamp32(longint'(slope_sums[c]) + longint'(v)));
      end
      OP_UPDATE: begin
        w = weights[c];
        d = steps[c];
        p = slopes[c];
        s = clamp32(longint'(slope_sums[c]) + ((decay_q * w) >>> FRAC_BITS));
        eps_s = (eps_q * s) >>> FRAC_BITS;
        sp = shrink_q * p;
        dw = 0;
        if (d < 0) begin
          if (s > 0) dw -= eps_s;
          if ((s <<< FRAC_BITS) >= sp) dw += (growth_q * d) >>> FRAC_BITS;
          else dw += quad_step(d, s, p);
        end else if (d > 0) begin
          if (s < 0) dw -= eps_s;
          if ((s <<< FRAC_BITS) <= sp) dw += (growth_q * d) >>> FRAC_BITS;
          else dw += quad_step(d, s, p);
        end else begin
          dw -= eps_s;
        end
        dw = clamp32(dw);
        nw = clamp32(w + dw);
        weights[c] = int'(nw);
        steps[c] = int'(dw);
        slopes[c] = int'(s);
        slope_sums[c] = 0;
        if (limit_on && nw > limit_q) begin
          if (restore_tally < 65535) restore_tally++;
          weights[c] = int'(restart_q);
          steps[c] = 0;
          slopes[c] = 0;
          r.overflowed = 1'b1;
          restores_seen++;
        end
      end
      default: ;
    endcase
    r.weight = weights[c];
    r.step = steps[c];
    r.count = restore_tally[15:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    outcome_t exp_r;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result weight=%0d step=%0d", $time, weight, step);
      end else begin
        exp_r = pending_results.pop_front();
        if (weight !== exp_r.weight) begin
          errors++;
          $display("%0t: weight expected %0d actual %0d", $time, exp_r.weight, weight);
        end
        if (step !== exp_r.step) begin
          errors++;
          $display("%0t: step expected %0d actual %0d", $time, exp_r.step, step);
        end
        if (overflowed !== exp_r.overflowed) begin
          errors++;
          $display("%0t: overflowed expected %0d actual %0d", $time,
                   exp_r.overflowed, overflowed);
        end
        if (overflow_count !== exp_r.count) begin
          errors++;
          $display("%0t: overflow_count expected %0d actual %0d", $time,
                   exp_r.count, overflow_count);
        end
      end
    end
  end

  task automatic send_item(op_t o, int c, int v, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    connection <= c[CONN_AW-1:0];
    value <= v;
    do @(posedge clk); while (busy);
    pending_results = {pending_results, apply_item(o, c, v)};
    items_sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STEP_RATE:  eps_q = longint'(data[30:0]);
      REG_DECAY_RATE: decay_q = longint'(data[30:0]);
      REG_MAX_GROWTH: growth_q = longint'(data[30:0]);
      REG_SHRINK:     shrink_q = longint'(data[16:0]);
      REG_LIMIT:      limit_q = longint'(data[30:0]);
      REG_LIMIT_EN:   limit_on = data[0];
      REG_RESTART:    restart_q = longint'(signed'(data));
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [31:0] e, logic [31:0] dcy, logic [31:0] g,
                           logic [31:0] sh, logic [31:0] lim, logic [31:0] en,
                           logic [31:0] rs);
    write_reg(REG_STEP_RATE, e);
    write_reg(REG_DECAY_RATE, dcy);
    write_reg(REG_MAX_GROWTH, g);
    write_reg(REG_SHRINK, sh);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_LIMIT_EN, en);
    write_reg(REG_RESTART, rs);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_ops_and_extremes;
    send_item(OP_WRITE, 0, 32'h7FFF_FFFF, 0);
    send_item(OP_WRITE, 1023, 32'h8000_0000, 0);
    send_item(OP_NONE, 0, 32'h1234_5678, 3);
    send_item(OP_ACCUM, 0, 32'h7FFF_FFFF, 0);
    send_item(OP_ACCUM, 0, 32'h7FFF_FFFF, 0);
    send_item(OP_UPDATE, 0, 0, 1);
    send_item(OP_ACCUM, 1023, 32'h8000_0000, 0);
    send_item(OP_ACCUM, 1023, 32'h8000_0000, 2);
    send_item(OP_UPDATE, 1023, -1, 0);
    send_item(OP_WRITE, 5, 32'h2710_0000, 0);
    send_item(OP_ACCUM, 5, -32'sd65536, 0);
    send_item(OP_UPDATE, 5, 0, 0);
    send_item(OP_ACCUM, 5, -32'sd131072, 0);
    send_item(OP_UPDATE, 5, 0, 0);
    send_item(OP_WRITE, 7, 32'h0001_0000, 0);
    send_item(OP_ACCUM, 7, 32'h0000_8000, 0);
    send_item(OP_UPDATE, 7, 0, 0);
    send_item(OP_ACCUM, 7, 32'h0000_4000, 0);
    send_item(OP_UPDATE, 7, 0, 0);
    send_item(OP_UPDATE, 7, 0, 0);
    drain();
  endtask

  task automatic test_zero_divisor;
    load_regs(32'h0001_0000, 0, 32'h0002_0000, 32'h0001_FFFF, 32'h7FFF_FFFF, 1, 0);
    send_item(OP_WRITE, 9, 0, 0);
    send_item(OP_ACCUM, 9, 32'h0001_0000, 0);
    send_item(OP_UPDATE, 9, 0, 0);
    send_item(OP_ACCUM, 9, 32'h0001_0000, 0);
    send_item(OP_UPDATE, 9, 0, 0);
    drain();
  endtask

  function automatic int draw_value();
    case ($urandom_range(0, 3))
      0: return int'($urandom);
      1: return int'($urandom_range(0, 4000000)) - 2000000;
      2: return int'($urandom_range(0, 200000)) - 100000;
      default: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  task automatic test_random_phase(int n);
    int c, v, gap, k;
    op_t o;
    bit burst;
    for (k = 0; k < 8; k++) pool[k] = $urandom_range(0, CONNECTIONS - 1);
    burst = 1'b0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) burst = ~burst;
      gap = burst ? 0 : $urandom_range(0, 17);
      c = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 7)]
                                      : $urandom_range(0, CONNECTIONS - 1);
      k = $urandom_range(0, 99);
      if (k < 12) o = OP_WRITE;
      else if (k < 58) o = OP_ACCUM;
      else if (k < 95) o = OP_UPDATE;
      else o = OP_NONE;
      if (!written[c]) o = OP_WRITE;
      v = draw_value();
      if (o == OP_WRITE && $urandom_range(0, 1) != 0) v = v >>> 8;
      send_item(o, c, v, gap);
    end
    drain();
  endtask

  task automatic test_register_sweep;
    test_random_phase(190);
    load_regs(0, 0, 0, 0, 0, 1, 32'h8000_0000);
    test_random_phase(190);
    load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_FFFF,
              32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
    test_random_phase(190);
    load_regs(32'h0000_4000, 32'h0000_0100, 32'h0001_C000, 32'h0001_0000,
              32'h0064_0000, 1, 32'h0000_8000);
    test_random_phase(190);
    load_regs($urandom, $urandom_range(0, 4096), $urandom_range(0, 32'h0004_0000),
              $urandom_range(0, 65536), $urandom_range(0, 32'h0400_0000), 1, $urandom);
    test_random_phase(190);
    load_regs(32'h000A_0000, 0, 32'h0002_0000, 43690, 32'h2710_0000, 1, 0);
    test_random_phase(180);
  endtask

  initial begin
    rst = 1'b1;
    start <= 1'b0;
    op <= OP_WRITE;
    connection <= '0;
    value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_STEP_RATE;
    cfg_data <= '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    restores_seen = 0;
    quad_hits = 0;
    cycles = 0;
    restore_tally = 0;
    eps_q = 655360;
    decay_q = 0;
    growth_q = 131072;
    shrink_q = 43690;
    limit_q = 655360000;
    limit_on = 1'b1;
    restart_q = 0;
    foreach (steps[i]) begin
      weights[i] = 0;
      steps[i] = 0;
      slopes[i] = 0;
      slope_sums[i] = 0;
      written[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ops_and_extremes();
    test_zero_divisor();
    test_register_sweep();
    $display("covered %0d beats, %0d results, %0d limit restorations,", items_sent,
             results_seen, restores_seen);
    $display("%0d quadratic steps over seven register settings", quad_hits);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
